@@ hw/rtl/gjk_pkg.sv @@
// ----------------------------------------------------------------------------
// gjk_pkg
// shared constants and codes for the gjk simplex update block
// ----------------------------------------------------------------------------
`default_nettype none

package gjk_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned DIR_BITS       = 56;
  localparam int unsigned SIZE_BITS      = 3;
  localparam int unsigned MAX_POINTS     = 4;

  localparam logic ACT_CLEAR = 1'b0;
  localparam logic ACT_ADD   = 1'b1;

endpackage

`default_nettype wire

@@ hw/rtl/gjk_if.sv @@
// ----------------------------------------------------------------------------
// gjk channel interfaces
// support point input channel and search direction result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface gjk_pt_if #(
  parameter int unsigned COORD_BITS = gjk_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] pt_x;
  logic signed [COORD_BITS-1:0] pt_y;
  logic signed [COORD_BITS-1:0] pt_z;

  modport source (output valid, action, pt_x, pt_y, pt_z, input ready);
  modport sink   (input valid, action, pt_x, pt_y, pt_z, output ready);
endinterface

interface gjk_dir_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gjk_pkg::DIR_BITS-1:0]  dir_x;
  logic signed [gjk_pkg::DIR_BITS-1:0]  dir_y;
  logic signed [gjk_pkg::DIR_BITS-1:0]  dir_z;
  logic                                 contains_origin;
  logic        [gjk_pkg::SIZE_BITS-1:0] simplex_size;

  modport source (output valid, dir_x, dir_y, dir_z, contains_origin, simplex_size,
                  input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, contains_origin, simplex_size,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gjk_simplex_update.sv @@
// ----------------------------------------------------------------------------
// gjk_simplex_update
// one step of the 3d gjk origin test on a simplex of up to four points
//
// in_i carries a support point and an action (clear then add, or add); a
// transfer pushes the point to the front of the simplex. out_o carries the
// next search direction, the origin-enclosed flag and the new simplex size,
// one result per input transfer.
// all products and dot products run through one signed multiply-accumulate
// unit, one product per cycle, under a small sequencer. the number of products
// in an item is set by its case, from none for a single point to the most for a
// tetrahedron falling back to a triangle and then a line.
// in_i is ready only while the sequencer is idle; a finished result sits in
// the output register, so the next point can be taken while out_o stalls.
// a stalled out_o holds its result; a new result waits until it is taken.
// reset empties the simplex and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module gjk_simplex_update #(
  parameter int unsigned COORD_BITS = gjk_pkg::COORD_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gjk_pt_if.sink     in_i,
  gjk_dir_if.source  out_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned MW = 2 * CW + 4;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned DW = gjk_pkg::DIR_BITS;
  localparam int unsigned XW = (AW > DW) ? AW : DW;
  localparam int unsigned SW = gjk_pkg::SIZE_BITS;

  localparam logic signed [XW-1:0] DMAX = XW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [XW-1:0] DMIN = ~DMAX;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DISP   = 5'd1;
  localparam logic [4:0] ST_LDOT   = 5'd2;
  localparam logic [4:0] ST_TCUU   = 5'd3;
  localparam logic [4:0] ST_TCUV   = 5'd4;
  localparam logic [4:0] ST_TCD    = 5'd5;
  localparam logic [4:0] ST_TRN    = 5'd6;
  localparam logic [4:0] ST_TRW1   = 5'd7;
  localparam logic [4:0] ST_TRD1   = 5'd8;
  localparam logic [4:0] ST_TRACAO = 5'd9;
  localparam logic [4:0] ST_TRW2   = 5'd10;
  localparam logic [4:0] ST_TRD2   = 5'd11;
  localparam logic [4:0] ST_TRD3   = 5'd12;
  localparam logic [4:0] ST_TEN1   = 5'd13;
  localparam logic [4:0] ST_TED1   = 5'd14;
  localparam logic [4:0] ST_TEN2   = 5'd15;
  localparam logic [4:0] ST_TED2   = 5'd16;
  localparam logic [4:0] ST_TEN3   = 5'd17;
  localparam logic [4:0] ST_TED3   = 5'd18;
  localparam logic [4:0] ST_FIN    = 5'd19;

  function automatic logic signed [DW-1:0] sat_dir(input logic signed [AW-1:0] v);
    logic signed [XW-1:0] e;
    e = XW'(v);
    if (e > DMAX) begin
      return DW'(DMAX);
    end else if (e < DMIN) begin
      return DW'(DMIN);
    end
    return e[DW-1:0];
  endfunction

  logic [4:0]              state_q, state_d;
  logic [2:0]              k_q, k_d;
  logic [SW-1:0]           cnt_q, cnt_d;
  logic                    tc_ac_q, tc_ac_d;
  logic                    hit_q, hit_d;
  logic                    ov_q, ov_d;

  logic signed [CW-1:0]    st_q [4][3];
  logic signed [CW-1:0]    st_d [4][3];
  logic signed [MW-1:0]    n_q [3];
  logic signed [MW-1:0]    n_d [3];
  logic signed [MW-1:0]    w_q [3];
  logic signed [MW-1:0]    w_d [3];
  logic signed [MW-1:0]    uu_q, uu_d, uv_q, uv_d;
  logic signed [AW-1:0]    acc_q, acc_d;
  logic signed [DW-1:0]    dir_q [3];
  logic signed [DW-1:0]    dir_d [3];
  logic signed [DW-1:0]    odir_q [3];
  logic signed [DW-1:0]    odir_d [3];
  logic                    ohit_q, ohit_d;
  logic [SW-1:0]           osize_q, osize_d;

  logic signed [MW-1:0]    vao [3];
  logic signed [MW-1:0]    vab [3];
  logic signed [MW-1:0]    vac [3];
  logic signed [MW-1:0]    vad [3];
  logic signed [MW-1:0]    vu  [3];
  logic signed [MW-1:0]    xv  [3];
  logic signed [MW-1:0]    yv  [3];

  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [AW-1:0]    prod_x, acc_nx;
  logic                    is_dot, is_cross, is_tcd, clr, sub, last, pos;
  logic [1:0]              c, i1, i2;
  logic                    j;
  logic                    in_xfer, out_load;
  logic [SW-1:0]           cnt_base;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vao[i] = -MW'(st_q[0][i]);
      vab[i] = MW'(st_q[1][i]) - MW'(st_q[0][i]);
      vac[i] = MW'(st_q[2][i]) - MW'(st_q[0][i]);
      vad[i] = MW'(st_q[3][i]) - MW'(st_q[0][i]);
      vu[i]  = tc_ac_q ? vac[i] : vab[i];
    end
  end

  always_comb begin
    is_dot   = 1'b0;
    is_cross = 1'b0;
    is_tcd   = 1'b0;
    xv       = vab;
    yv       = vao;
    case (state_q)
      ST_LDOT:   begin is_dot = 1'b1; xv = vab; yv = vao; end
      ST_TCUU:   begin is_dot = 1'b1; xv = vu;  yv = vu;  end
      ST_TCUV:   begin is_dot = 1'b1; xv = vu;  yv = vao; end
      ST_TCD:    begin is_tcd = 1'b1; end
      ST_TRN:    begin is_cross = 1'b1; xv = vab; yv = vac; end
      ST_TRW1:   begin is_cross = 1'b1; xv = vac; yv = vao; end
      ST_TRD1:   begin is_dot = 1'b1; xv = n_q; yv = w_q; end
      ST_TRACAO: begin is_dot = 1'b1; xv = vac; yv = vao; end
      ST_TRW2:   begin is_cross = 1'b1; xv = vao; yv = vab; end
      ST_TRD2:   begin is_dot = 1'b1; xv = n_q; yv = w_q; end
      ST_TRD3:   begin is_dot = 1'b1; xv = n_q; yv = vao; end
      ST_TEN1:   begin is_cross = 1'b1; xv = vab; yv = vac; end
      ST_TED1:   begin is_dot = 1'b1; xv = n_q; yv = vao; end
      ST_TEN2:   begin is_cross = 1'b1; xv = vac; yv = vad; end
      ST_TED2:   begin is_dot = 1'b1; xv = n_q; yv = vao; end
      ST_TEN3:   begin is_cross = 1'b1; xv = vad; yv = vab; end
      ST_TED3:   begin is_dot = 1'b1; xv = n_q; yv = vao; end
      default:   begin end
    endcase
  end

  // shared multiply-accumulate unit
  always_comb begin
    c     = k_q[2:1];
    j     = k_q[0];
    i1    = (c == 2'd2) ? 2'd0 : c + 2'd1;
    i2    = (c == 2'd0) ? 2'd2 : c - 2'd1;
    mul_a = '0;
    mul_b = '0;
    clr   = 1'b1;
    sub   = 1'b0;
    if (is_dot) begin
      mul_a = xv[k_q[1:0]];
      mul_b = yv[k_q[1:0]];
      clr   = (k_q == 3'd0);
    end else if (is_cross) begin
      mul_a = j ? xv[i2] : xv[i1];
      mul_b = j ? yv[i1] : yv[i2];
      clr   = !j;
      sub   = j;
    end else if (is_tcd) begin
      mul_a = j ? uv_q : uu_q;
      mul_b = j ? vu[c] : vao[c];
      clr   = !j;
      sub   = j;
    end
    prod   = mul_a * mul_b;
    prod_x = AW'(prod);
    if (clr) begin
      acc_nx = sub ? -prod_x : prod_x;
    end else begin
      acc_nx = sub ? acc_q - prod_x : acc_q + prod_x;
    end
    last = is_dot ? (k_q == 3'd2) : (k_q == 3'd5);
    pos  = !acc_nx[AW-1] && (acc_nx != '0);
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_FIN) && (!ov_q || out_o.ready);
  assign cnt_base   = (in_i.action == gjk_pkg::ACT_CLEAR) ? '0 : cnt_q;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    tc_ac_d = tc_ac_q;
    hit_d   = hit_q;
    st_d    = st_q;
    n_d     = n_q;
    w_d     = w_q;
    uu_d    = uu_q;
    uv_d    = uv_q;
    acc_d   = acc_q;
    dir_d   = dir_q;
    ov_d    = ov_q;
    odir_d  = odir_q;
    ohit_d  = ohit_q;
    osize_d = osize_q;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    if (is_dot || is_cross || is_tcd) begin
      acc_d = acc_nx;
      k_d   = last ? 3'd0 : k_q + 3'd1;
      if (is_cross && j) begin
        if (state_q == ST_TRW1 || state_q == ST_TRW2) begin
          w_d[c] = acc_nx[MW-1:0];
        end else begin
          n_d[c] = acc_nx[MW-1:0];
        end
      end
      if (is_tcd && j) begin
        dir_d[c] = sat_dir(acc_nx);
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          st_d[3]    = st_q[2];
          st_d[2]    = st_q[1];
          st_d[1]    = st_q[0];
          st_d[0][0] = in_i.pt_x;
          st_d[0][1] = in_i.pt_y;
          st_d[0][2] = in_i.pt_z;
          cnt_d      = (cnt_base == SW'(gjk_pkg::MAX_POINTS)) ? cnt_base
                                                               : cnt_base + SW'(1);
          hit_d      = 1'b0;
          tc_ac_d    = 1'b0;
          k_d        = 3'd0;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        case (cnt_q)
          SW'(1): begin
            for (int i = 0; i < 3; i++) dir_d[i] = DW'(vao[i]);
            state_d = ST_FIN;
          end
          SW'(2):  state_d = ST_LDOT;
          SW'(3):  state_d = ST_TRN;
          default: state_d = ST_TEN1;
        endcase
      end
      ST_LDOT: begin
        if (last) begin
          if (pos) begin
            tc_ac_d = 1'b0;
            state_d = ST_TCUU;
          end else begin
            cnt_d = SW'(1);
            for (int i = 0; i < 3; i++) dir_d[i] = DW'(vao[i]);
            state_d = ST_FIN;
          end
        end
      end
      ST_TCUU: begin
        if (last) begin
          uu_d    = acc_nx[MW-1:0];
          state_d = ST_TCUV;
        end
      end
      ST_TCUV: begin
        if (last) begin
          uv_d    = acc_nx[MW-1:0];
          state_d = ST_TCD;
        end
      end
      ST_TCD: begin
        if (last) state_d = ST_FIN;
      end
      ST_TRN: begin
        if (last) state_d = ST_TRW1;
      end
      ST_TRW1: begin
        if (last) state_d = ST_TRD1;
      end
      ST_TRD1: begin
        if (last) state_d = pos ? ST_TRACAO : ST_TRW2;
      end
      ST_TRACAO: begin
        if (last) begin
          cnt_d = SW'(2);
          if (pos) begin
            st_d[1] = st_q[2];
            tc_ac_d = 1'b1;
            state_d = ST_TCUU;
          end else begin
            state_d = ST_LDOT;
          end
        end
      end
      ST_TRW2: begin
        if (last) state_d = ST_TRD2;
      end
      ST_TRD2: begin
        if (last) begin
          if (pos) begin
            cnt_d   = SW'(2);
            state_d = ST_LDOT;
          end else begin
            state_d = ST_TRD3;
          end
        end
      end
      ST_TRD3: begin
        if (last) begin
          if (pos) begin
            for (int i = 0; i < 3; i++) dir_d[i] = DW'(n_q[i]);
          end else begin
            st_d[1] = st_q[2];
            st_d[2] = st_q[1];
            for (int i = 0; i < 3; i++) dir_d[i] = DW'(-n_q[i]);
          end
          state_d = ST_FIN;
        end
      end
      ST_TEN1: begin
        if (last) state_d = ST_TED1;
      end
      ST_TED1: begin
        if (last) begin
          if (pos) begin
            cnt_d   = SW'(3);
            state_d = ST_TRN;
          end else begin
            state_d = ST_TEN2;
          end
        end
      end
      ST_TEN2: begin
        if (last) state_d = ST_TED2;
      end
      ST_TED2: begin
        if (last) begin
          if (pos) begin
            st_d[1] = st_q[2];
            st_d[2] = st_q[3];
            cnt_d   = SW'(3);
            state_d = ST_TRN;
          end else begin
            state_d = ST_TEN3;
          end
        end
      end
      ST_TEN3: begin
        if (last) state_d = ST_TED3;
      end
      ST_TED3: begin
        if (last) begin
          if (pos) begin
            st_d[1] = st_q[3];
            st_d[2] = st_q[1];
            cnt_d   = SW'(3);
            state_d = ST_TRN;
          end else begin
            hit_d = 1'b1;
            for (int i = 0; i < 3; i++) dir_d[i] = '0;
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_load) begin
          ov_d    = 1'b1;
          odir_d  = dir_q;
          ohit_d  = hit_q;
          osize_d = cnt_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      cnt_q   <= '0;
      tc_ac_q <= 1'b0;
      hit_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      tc_ac_q <= tc_ac_d;
      hit_q   <= hit_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    n_q     <= n_d;
    w_q     <= w_d;
    uu_q    <= uu_d;
    uv_q    <= uv_d;
    acc_q   <= acc_d;
    dir_q   <= dir_d;
    odir_q  <= odir_d;
    ohit_q  <= ohit_d;
    osize_q <= osize_d;
  end

  assign out_o.valid           = ov_q;
  assign out_o.dir_x           = odir_q[0];
  assign out_o.dir_y           = odir_q[1];
  assign out_o.dir_z           = odir_q[2];
  assign out_o.contains_origin = ohit_q;
  assign out_o.simplex_size    = osize_q;

endmodule

`default_nettype wire
